@@ rtl/assert_macros.svh @@
// Assertion macros shared by the odometry RTL.
// Has no dependencies; the top level includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset has been released.
`define DDO_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DDO_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ddo_pkg.sv @@
// Package for the differential-drive odometry block: types, widths,
// constants and the CORDIC arctangent table. Depends on nothing.
package ddo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IW          = 5;
    localparam int CW               = 34;
    localparam int ZW               = 32;
    localparam int MUL_AW           = 36;
    localparam int MUL_BW           = 34;
    localparam int MUL_PW           = MUL_AW + MUL_BW;

    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

    localparam logic [31:0] ANGLE_GAIN_RST  = 32'd683565;
    localparam logic [15:0] MM_PER_TICK_RST = 16'd655;
    localparam logic [31:0] EIGHTH_TURN     = 32'h2000_0000;

    localparam logic CFG_ANGLE_GAIN  = 1'b0;
    localparam logic CFG_MM_PER_TICK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_ANGLE,
        S_CORDIC,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_OUT
    } ddo_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    function automatic logic [31:0] atan_lut(input logic [ATAN_IW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/diff_drive_odometry_top.sv @@
// Odometry top level: sequencer, configuration, position and heading state.
// An item's result is valid only after the CORDIC rotations and five passes through the
// shared multiplier; no new item is taken until that result is loaded into the output
// register, and later while an earlier result still waits at the output.
// Reset is asynchronous, active low; it clears position and heading and restores the
// configuration defaults.
module diff_drive_odometry_top
#(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // right_ticks [15:0], left_ticks [31:16]
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // position_x [47:0], position_y [95:48], heading [127:96]
    output logic [127:0] m_tdata
);
    import ddo_pkg::*;

    `include "assert_macros.svh"

    localparam int SW = 56;
    localparam logic signed [SW-1:0] POS_MAX = $signed({9'h000, {47{1'b1}}});
    localparam logic signed [SW-1:0] POS_MIN = $signed({9'h1FF, 47'h0});

    ddo_state_t state_reg;
    ddo_state_t state_next;

    logic [31:0]          angle_gain_reg;
    logic [15:0]          mm_per_tick_reg;
    logic signed [47:0]   pos_x_reg;
    logic signed [47:0]   pos_y_reg;
    logic [31:0]          heading_reg;
    logic signed [16:0]   sum_reg;
    logic signed [16:0]   diff_reg;
    logic [1:0]           quad_reg;
    logic                 axis_reg;
    logic signed [34:0]   u_reg;
    logic                 m_tvalid_reg;
    logic [127:0]         m_tdata_reg;

    logic signed [MUL_AW-1:0] op_a;
    logic signed [MUL_BW-1:0] op_b;
    logic signed [MUL_PW-1:0] prod;
    logic                     cordic_start;
    logic signed [CW-1:0]     cx;
    logic signed [CW-1:0]     cy;
    cordic_stat_t             cstat;

    logic [31:0]          head_new;
    logic [31:0]          head_bias;
    logic [1:0]           quad;
    logic [31:0]          resid;
    logic signed [CW-1:0] cos_v;
    logic signed [CW-1:0] sin_v;
    logic signed [CW-1:0] proj_v;
    logic signed [MUL_PW-1:0] rnd_u;
    logic signed [MUL_PW-1:0] rnd_d;
    logic signed [39:0]   delta;
    logic signed [SW-1:0] pos_sel;
    logic signed [SW-1:0] pos_sum;
    logic signed [47:0]   pos_sat;
    logic                 in_acc;
    logic                 out_free;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign head_new  = heading_reg + prod[31:0];
    assign head_bias = head_new + EIGHTH_TURN;
    assign quad      = head_bias[31:30];
    assign resid     = head_new - {quad, 30'b0};

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = cx;
                sin_v = cy;
            end
            2'd1:
            begin
                cos_v = -cy;
                sin_v = cx;
            end
            2'd2:
            begin
                cos_v = -cx;
                sin_v = -cy;
            end
            default:
            begin
                cos_v = cy;
                sin_v = -cx;
            end
        endcase
    end

    assign proj_v  = axis_reg ? sin_v : cos_v;
    assign rnd_u   = prod + MUL_PW'(16384);
    assign rnd_d   = prod + MUL_PW'(32768);
    assign delta   = rnd_d[55:16];
    assign pos_sel = axis_reg ? SW'(pos_y_reg) : SW'(pos_x_reg);
    assign pos_sum = pos_sel + SW'(delta);

    always_comb
    begin
        if (pos_sum > POS_MAX)
        begin
            pos_sat = POS_MAX[47:0];
        end
        else if (pos_sum < POS_MIN)
        begin
            pos_sat = POS_MIN[47:0];
        end
        else
        begin
            pos_sat = pos_sum[47:0];
        end
    end

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            S_HEAD:
            begin
                op_a = MUL_AW'(diff_reg);
                op_b = $signed({2'b00, angle_gain_reg});
            end
            S_P1:
            begin
                op_a = MUL_AW'(sum_reg);
                op_b = proj_v;
            end
            S_P3:
            begin
                op_a = MUL_AW'(u_reg);
                op_b = $signed({18'h0, mm_per_tick_reg});
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    ddo_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .z_in  ($signed(resid)),
        .x_out (cx),
        .y_out (cy),
        .stat  (cstat)
    );

    always_comb
    begin
        state_next   = state_reg;
        cordic_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                cordic_start = 1'b1;
                state_next   = S_CORDIC;
            end
            S_CORDIC:
            begin
                if (cstat.done)
                begin
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                state_next = S_P2;
            end
            S_P2:
            begin
                state_next = S_P3;
            end
            S_P3:
            begin
                state_next = S_P4;
            end
            S_P4:
            begin
                state_next = axis_reg ? S_OUT : S_P1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_gain_reg  <= ANGLE_GAIN_RST;
            mm_per_tick_reg <= MM_PER_TICK_RST;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            heading_reg     <= '0;
            axis_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_ANGLE_GAIN:  angle_gain_reg  <= cfg_data;
                    CFG_MM_PER_TICK: mm_per_tick_reg <= cfg_data[15:0];
                    default:         angle_gain_reg  <= angle_gain_reg;
                endcase
            end
            if (state_reg == S_ANGLE)
            begin
                heading_reg <= head_new;
                axis_reg    <= 1'b0;
            end
            if (state_reg == S_P4)
            begin
                if (axis_reg)
                begin
                    pos_y_reg <= pos_sat;
                end
                else
                begin
                    pos_x_reg <= pos_sat;
                end
                axis_reg <= !axis_reg;
            end
            if (state_reg == S_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            sum_reg  <= 17'($signed(s_tdata[15:0])) + 17'($signed(s_tdata[31:16]));
            diff_reg <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[31:16]));
        end
        if (state_reg == S_ANGLE)
        begin
            quad_reg <= quad;
        end
        if (state_reg == S_P2)
        begin
            u_reg <= rnd_u[49:15];
        end
        if (state_reg == S_OUT && out_free)
        begin
            m_tdata_reg <= {heading_reg, pos_y_reg, pos_x_reg};
        end
    end

    `DDO_ASSERT(a_busy_after_accept, in_acc |=> !s_tready, "ready after an accepted item")
    `DDO_ASSERT_ALWAYS(a_cordic_done, cstat.done |-> state_reg == S_CORDIC, "stray CORDIC done")
    `DDO_ASSERT(a_out_hold, (state_reg == S_OUT) && m_tvalid_reg && !m_tready |=> (state_reg == S_OUT), "result loaded over an untaken one")
    `DDO_ASSERT(a_cordic_idle_start, cordic_start |-> !cstat.busy, "CORDIC restarted while busy")

endmodule

@@ rtl/ddo_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on ddo_pkg for the operand widths.
module ddo_mul
(
    input  logic                              clk,
    input  logic signed [ddo_pkg::MUL_AW-1:0] op_a,
    input  logic signed [ddo_pkg::MUL_BW-1:0] op_b,
    output logic signed [ddo_pkg::MUL_PW-1:0] prod
);
    import ddo_pkg::*;

    logic signed [MUL_PW-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_PW'(op_a) * MUL_PW'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ rtl/ddo_cordic.sv @@
// Iterative CORDIC in rotation mode, one micro-rotation per cycle.
// Depends on ddo_pkg for widths, the gain constant and the arctangent table.
module ddo_cordic
#(
    parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [ddo_pkg::ZW-1:0] z_in,
    output logic signed [ddo_pkg::CW-1:0] x_out,
    output logic signed [ddo_pkg::CW-1:0] y_out,
    output ddo_pkg::cordic_stat_t         stat
);
    import ddo_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IW-1:0]        iter_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] da;

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign da = $signed(atan_lut(ATAN_IW'(iter_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (iter_reg == IW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_K;
            y_reg <= '0;
            z_reg <= z_in;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - da;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + da;
            end
        end
    end

    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ tb/odo_scoreboard_pkg.sv @@
// Scoreboard for the differential-drive odometry testbench: predicts pose
// items from accepted tick items and checks the results. Depends on ddo_pkg.
`timescale 1ns / 1ps
package odo_scoreboard_pkg;

    localparam longint POS_MAX = 64'sd140737488355327;
    localparam longint POS_MIN = -POS_MAX - 64'sd1;
    localparam longint ROT_START = 64'sd652032874;

    localparam bit [31:0] ATAN_TURNS [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct {
        bit [47:0] x;
        bit [47:0] y;
        bit [31:0] heading;
    } pose_t;

    class odo_scoreboard;
        bit [31:0] angle_gain;
        bit [15:0] mm_per_tick;
        longint pos_x;
        longint pos_y;
        bit [31:0] heading;
        pose_t expected_poses[$];
        int mismatches;

        function new();
            angle_gain = ddo_pkg::ANGLE_GAIN_RST;
            mm_per_tick = ddo_pkg::MM_PER_TICK_RST;
            pos_x = 0;
            pos_y = 0;
            heading = '0;
            mismatches = 0;
        endfunction

        function void set_register(logic index, bit [31:0] value);
            if (index == ddo_pkg::CFG_ANGLE_GAIN)
            begin
                angle_gain = value;
            end
            else
            begin
                mm_per_tick = value[15:0];
            end
        endfunction

        // Rounds the projected tick sum to Q.16 millimetres.
        function longint to_mm(longint sum, longint trig);
            longint t;
            longint u;
            t = sum * trig;
            u = (t + 64'sd16384) >>> 15;
            return (u * longint'(mm_per_tick) + 64'sd32768) >>> 16;
        endfunction

        function longint clamp_pos(longint p);
            if (p > POS_MAX)
            begin
                return POS_MAX;
            end
            if (p < POS_MIN)
            begin
                return POS_MIN;
            end
            return p;
        endfunction

        function void note_item(bit signed [15:0] right, bit signed [15:0] left);
            longint r;
            longint l;
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint c;
            longint s;
            bit [31:0] shifted;
            bit [31:0] residue;
            bit [1:0] quad;
            pose_t p;
            r = right;
            l = left;
            heading = heading + 32'((r - l) * longint'(angle_gain));
            shifted = heading + ddo_pkg::EIGHTH_TURN;
            quad = shifted[31:30];
            residue = heading - {quad, 30'd0};
            z = longint'(signed'(residue));
            x = ROT_START;
            y = 0;
            for (int i = 0; i < ddo_pkg::CORDIC_STEPS_DEF && i < 30; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_TURNS[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_TURNS[i]);
                end
            end
            case (quad)
                2'd0:
                begin
                    c = x;
                    s = y;
                end
                2'd1:
                begin
                    c = -y;
                    s = x;
                end
                2'd2:
                begin
                    c = -x;
                    s = -y;
                end
                default:
                begin
                    c = y;
                    s = -x;
                end
            endcase
            pos_x = clamp_pos(pos_x + to_mm(r + l, c));
            pos_y = clamp_pos(pos_y + to_mm(r + l, s));
            p.x = pos_x[47:0];
            p.y = pos_y[47:0];
            p.heading = heading;
            expected_poses.push_back(p);
        endfunction

        function void check_result(logic [127:0] data);
            pose_t want;
            if (expected_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result item %h with none pending.", data);
                end
                return;
            end
            want = expected_poses.pop_front();
            if (data[47:0] !== want.x || data[95:48] !== want.y
                || data[127:96] !== want.heading)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Pose mismatch at %0t: x %h/%h y %h/%h heading %h/%h (exp/got).",
                             $realtime, want.x, data[47:0], want.y, data[95:48],
                             want.heading, data[127:96]);
                end
            end
        endfunction

        function void flush_leftovers();
            if (expected_poses.size() != 0)
            begin
                mismatches += expected_poses.size();
                $display("%0d expected result items never arrived.",
                         expected_poses.size());
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
// Top-level testbench for diff_drive_odometry_top: directed, random and
// extreme stimulus with random stalls. Depends on ddo_pkg and odo_scoreboard_pkg.
`timescale 1ns / 1ps
module tb;
    import odo_scoreboard_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    bit           steady = 1'b0;
    odo_scoreboard board;

    diff_drive_odometry_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic int random_ticks();
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            v = int'($urandom_range(0, 400)) - 200;
        end
        else if (roll < 60)
        begin
            v = int'($urandom_range(0, 6000)) - 3000;
        end
        else if (roll < 90)
        begin
            v = int'($signed(16'($urandom)));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: v = 32767;
                1: v = -32768;
                2: v = -1;
                default: v = 0;
            endcase
        end
        return v;
    endfunction

    task automatic write_register(input logic index, input logic [31:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = index;
        cfg_data = value;
        @(posedge clk);
        board.set_register(index, value);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_item(input int right, input int left);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {16'(left), 16'(right)};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_item(16'(right), 16'(left));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (board.expected_poses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            board.check_result(m_tdata);
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                m_tready = 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else if (m_tready)
            begin
                hold = pick_gap();
                if (hold > 0)
                begin
                    m_tready = 1'b0;
                end
                else
                begin
                    hold = $urandom_range(0, 6);
                end
            end
            else
            begin
                m_tready = 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    initial
    begin
        #(100_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int right;
        int left;
        logic [31:0] gain;
        logic [15:0] scale;
        board = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero, unit, extreme and alternating tick counts.
        send_item(0, 0);
        send_item(1, 0);
        send_item(0, 1);
        send_item(-1, 0);
        send_item(32767, 32767);
        send_item(-32768, -32768);
        send_item(32767, -32768);
        send_item(-32768, 32767);
        send_item(21845, -21846);
        send_item(-21846, 21845);
        wait_drained();

        // Quarter turns land exactly on each quadrant; junk above mm_per_tick.
        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'h4000_0000);
        write_register(ddo_pkg::CFG_MM_PER_TICK, 32'hFFFF_FFFF);
        repeat (4) send_item(1000, 999);
        wait_drained();

        // An eighth turn sits on the quadrant reduction boundary.
        write_register(ddo_pkg::CFG_ANGLE_GAIN, ddo_pkg::EIGHTH_TURN);
        send_item(1, 0);
        send_item(2000, 1999);
        wait_drained();

        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'hFFFF_FFFF);
        write_register(ddo_pkg::CFG_MM_PER_TICK, 32'h0000_0000);
        send_item(32767, -32768);
        send_item(-32768, -32768);
        wait_drained();

        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'h0000_0000);
        write_register(ddo_pkg::CFG_MM_PER_TICK, 32'h0000_0001);
        send_item(32767, 32767);
        send_item(-5, 3);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 4))
                0: gain = 32'h0000_0000;
                1: gain = 32'hFFFF_FFFF;
                2: gain = ddo_pkg::ANGLE_GAIN_RST;
                3: gain = $urandom_range(0, 2000000);
                default: gain = $urandom;
            endcase
            case ($urandom_range(0, 3))
                0: scale = 16'h0000;
                1: scale = 16'hFFFF;
                2: scale = ddo_pkg::MM_PER_TICK_RST;
                default: scale = 16'($urandom);
            endcase
            write_register(ddo_pkg::CFG_ANGLE_GAIN, gain);
            write_register(ddo_pkg::CFG_MM_PER_TICK, {16'($urandom), scale});
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 220; n++)
            begin
                if (n == 110)
                begin
                    wait_drained();
                end
                right = random_ticks();
                if ($urandom_range(0, 9) < 6)
                begin
                    left = right + int'($urandom_range(0, 64)) - 32;
                    if (left > 32767)
                    begin
                        left = 32767;
                    end
                    if (left < -32768)
                    begin
                        left = -32768;
                    end
                end
                else
                begin
                    left = random_ticks();
                end
                send_item(right, left);
            end
            wait_drained();
        end

        // Point the heading at zero, then take the largest steps along X.
        steady = 1'b1;
        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'h0 - board.heading);
        send_item(1, 0);
        wait_drained();
        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'h0000_0000);
        write_register(ddo_pkg::CFG_MM_PER_TICK, 32'h0000_FFFF);
        repeat (8) send_item(32767, 32767);
        wait_drained();

        // Turn round and drive back.
        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'h8000_0000);
        send_item(1, 0);
        wait_drained();
        write_register(ddo_pkg::CFG_ANGLE_GAIN, 32'h0000_0000);
        steady = 1'b0;
        repeat (4) send_item(32767, 32767);

        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();
        repeat (ddo_pkg::CORDIC_STEPS_DEF + 16) @(posedge clk);
        board.flush_leftovers();
        if (board.mismatches == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
